### rtl/rsu_pkg.sv
// Shared types, constants and codes of the RAID4 request segmenter.
// Used by every module of the block; depends on nothing.
package rsu_pkg;

	parameter int POS_W        = 48;
	parameter int LEN_W        = 32;
	parameter int BS_W         = 17;
	parameter int DC_W         = 5;
	parameter int DRV_W        = 4;
	parameter int ACT_W        = 3;
	parameter int CFG_IDX_W    = 2;
	parameter int BS_MAX       = 65536;
	parameter int DC_MIN       = 3;
	parameter int MAX_DRIVES   = 16;
	parameter int MAX_SEGMENTS = 64;
	parameter int QUEUE_DEPTH  = 2;
	parameter int DIV_STEPS    = 2;
	parameter int MUL_SPLIT    = 24;
	parameter int PROD_W       = MUL_SPLIT + BS_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UNIT_BYTES    = 2'd0,
		REG_DRIVE_COUNT   = 2'd1,
		REG_MISSING_DRIVE = 2'd2
	} cfg_reg_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_READ        = 3'd0,
		ACT_RECON_READ  = 3'd1,
		ACT_WRITE_RMW   = 3'd2,
		ACT_WRITE_NOPAR = 3'd3,
		ACT_DEGRADED    = 3'd4
	} act_t;

	typedef enum logic [3:0] {
		F_IDLE,
		F_DIV1_GO,
		F_DIV1_WAIT,
		F_DIV2_GO,
		F_DIV2_WAIT,
		F_MUL_LO,
		F_MUL_HI,
		F_ADD,
		F_PUSH
	} front_state_t;

	typedef struct packed {
		logic [BS_W-1:0] unit_bytes;
		logic [DC_W-1:0] drive_count;
		logic [DC_W-1:0] missing_drive;
	} cfg_t;

	typedef struct packed {
		logic             cmd;
		logic [DRV_W-1:0] drv0;
		logic [DRV_W-1:0] data_drives;
		logic [POS_W-1:0] qbase;
		logic [BS_W-1:0]  bo;
		logic [BS_W-1:0]  bs;
		logic [LEN_W-1:0] len;
		logic             trunc;
		logic             miss_en;
		logic [DC_W-1:0]  miss_idx;
		logic             miss_par;
	} desc_t;

	typedef struct packed {
		logic [DRV_W-1:0] drive;
		logic [POS_W-1:0] drive_offset;
		logic [BS_W-1:0]  segment_length;
		logic [LEN_W-1:0] buffer_offset;
		act_t             action;
		logic             overflow;
		logic             last;
	} seg_t;

endpackage

### rtl/raid4_request_segmenter_unit.sv
// RAID4 request segmenter: splits a byte request into per-stripe-unit drive segments.
// A request is accepted, its first block located by two passes of a shared divider
// (two quotient bits per cycle) and a split 48x17 multiply, and its descriptor is then
// pushed into the queue; the front end takes a new request only after that push, so it
// stalls while the queue is full. The emitter delivers one segment per cycle while the
// output is not stalled and loads the next descriptor only after the last segment of
// a request; the front end works on the next request meanwhile. Zero-length requests
// are accepted and produce nothing. Configuration registers hold block size, drive
// count and missing drive; write them only while idle. Uses rsu_pkg, rsu_front,
// rsu_queue and rsu_back.
module raid4_request_segmenter_unit
	import rsu_pkg::*;
#(
	parameter int MAX_SEG     = MAX_SEGMENTS,
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BS_W-1:0]      cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 command,
	input  logic [POS_W-1:0]     byte_offset,
	input  logic [LEN_W-1:0]     req_length,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DRV_W-1:0]     drive,
	output logic [POS_W-1:0]     drive_offset,
	output logic [BS_W-1:0]      segment_length,
	output logic [LEN_W-1:0]     buffer_offset,
	output logic [ACT_W-1:0]     action,
	output logic                 overflow,
	output logic                 last
);

	cfg_t  cfg_q;
	logic  push_valid, push_ready, pop_valid, pop_ready;
	desc_t push_data, pop_data;
	seg_t  out_seg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unit_bytes    <= BS_W'(4096);
			cfg_q.drive_count   <= DC_W'(4);
			cfg_q.missing_drive <= DC_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_UNIT_BYTES:    cfg_q.unit_bytes    <= cfg_data;
				REG_DRIVE_COUNT:   cfg_q.drive_count   <= cfg_data[DC_W-1:0];
				REG_MISSING_DRIVE: cfg_q.missing_drive <= cfg_data[DC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rsu_front #(
		.MAX_SEG (MAX_SEG)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.byte_offset (byte_offset),
		.req_length  (req_length),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	rsu_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	rsu_back #(
		.MAX_SEG (MAX_SEG)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (pop_valid),
		.desc_ready (pop_ready),
		.desc       (pop_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_seg    (out_seg)
	);

	assign drive          = out_seg.drive;
	assign drive_offset   = out_seg.drive_offset;
	assign segment_length = out_seg.segment_length;
	assign buffer_offset  = out_seg.buffer_offset;
	assign action         = out_seg.action;
	assign overflow       = out_seg.overflow;
	assign last           = out_seg.last;

endmodule

### rtl/rsu_divider.sv
// Shared serial divider, DIV_STEPS quotient bits per cycle.
// Divides a POS_W dividend by a BS_W divisor; uses rsu_pkg.
module rsu_divider
	import rsu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [POS_W-1:0] dividend,
	input  logic [BS_W-1:0]  divisor,
	output logic             done,
	output logic [POS_W-1:0] quotient,
	output logic [BS_W-1:0]  remainder
);

	localparam int DivIter = (POS_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int CntW    = (DivIter > 1) ? $clog2(DivIter) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CntW-1:0]  cnt_q;
	logic [POS_W-1:0] quo_q;
	logic [BS_W-1:0]  rem_q;
	logic [BS_W-1:0]  div_q;
	logic [POS_W-1:0] quo_nx;
	logic [BS_W-1:0]  rem_nx;
	logic [BS_W:0]    trial;

	always_comb begin
		quo_nx = quo_q;
		rem_nx = rem_q;
		trial  = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial  = {rem_nx, quo_nx[POS_W-1]};
			quo_nx = {quo_nx[POS_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				trial     = trial - {1'b0, div_q};
				quo_nx[0] = 1'b1;
			end
			rem_nx = trial[BS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(DivIter - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### rtl/rsu_front.sv
// Request front end: accepts a request, locates its first block and builds a descriptor.
// Uses rsu_pkg and rsu_divider.
module rsu_front
	import rsu_pkg::*;
#(
	parameter int MAX_SEG = MAX_SEGMENTS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             command,
	input  logic [POS_W-1:0] byte_offset,
	input  logic [LEN_W-1:0] req_length,
	output logic             push_valid,
	input  logic             push_ready,
	output desc_t            push_data
);

	front_state_t     state_q, state_nx;
	logic             div_start, div_done;
	logic [POS_W-1:0] div_dividend, div_quotient;
	logic [BS_W-1:0]  div_divisor, div_remainder;

	logic [BS_W-1:0]  bs_clamp;
	logic [DC_W-1:0]  dc_clamp;

	logic             cmd_q;
	logic [POS_W-1:0] pos_q;
	logic [LEN_W-1:0] len_q;
	logic [BS_W-1:0]  bs_q;
	logic [DRV_W-1:0] dd_q;
	logic             miss_en_q;
	logic [DC_W-1:0]  miss_idx_q;
	logic             miss_par_q;
	logic [POS_W-1:0] blk_q;
	logic [BS_W-1:0]  bo_q;
	logic [POS_W-1:0] quo_q;
	logic [DRV_W-1:0] drv_q;
	logic [PROD_W-1:0] prod_q;
	logic [POS_W-1:0] acc_q;
	logic             trunc_q;

	rsu_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quotient),
		.remainder (div_remainder)
	);

	always_comb begin
		if (cfg.unit_bytes == '0)
			bs_clamp = BS_W'(1);
		else if (cfg.unit_bytes > BS_W'(BS_MAX))
			bs_clamp = BS_W'(BS_MAX);
		else
			bs_clamp = cfg.unit_bytes;
		if (cfg.drive_count < DC_W'(DC_MIN))
			dc_clamp = DC_W'(DC_MIN);
		else if (cfg.drive_count > DC_W'(MAX_DRIVES))
			dc_clamp = DC_W'(MAX_DRIVES);
		else
			dc_clamp = cfg.drive_count;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (in_valid && req_length != '0)
					state_nx = F_DIV1_GO;
			end
			F_DIV1_GO:   state_nx = F_DIV1_WAIT;
			F_DIV1_WAIT: begin
				if (div_done)
					state_nx = F_DIV2_GO;
			end
			F_DIV2_GO:   state_nx = F_DIV2_WAIT;
			F_DIV2_WAIT: begin
				if (div_done)
					state_nx = F_MUL_LO;
			end
			F_MUL_LO:    state_nx = F_MUL_HI;
			F_MUL_HI:    state_nx = F_ADD;
			F_ADD:       state_nx = F_PUSH;
			F_PUSH: begin
				if (push_ready)
					state_nx = F_IDLE;
			end
			default:     state_nx = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		div_start    = 1'b0;
		push_valid   = 1'b0;
		div_dividend = pos_q;
		div_divisor  = bs_q;
		unique case (state_q)
			F_IDLE:    in_ready = 1'b1;
			F_DIV1_GO: div_start = 1'b1;
			F_DIV2_GO: begin
				div_start    = 1'b1;
				div_dividend = blk_q;
				div_divisor  = BS_W'(dd_q);
			end
			F_PUSH:    push_valid = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= F_IDLE;
		else
			state_q <= state_nx;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				cmd_q      <= command;
				pos_q      <= byte_offset;
				len_q      <= req_length;
				bs_q       <= bs_clamp;
				dd_q       <= DRV_W'(dc_clamp - 1'b1);
				miss_en_q  <= cfg.missing_drive < dc_clamp;
				miss_idx_q <= cfg.missing_drive;
				miss_par_q <= cfg.missing_drive == (dc_clamp - 1'b1);
			end
			F_DIV1_WAIT: begin
				if (div_done) begin
					blk_q <= div_quotient;
					bo_q  <= div_remainder;
				end
			end
			F_DIV2_GO: begin
				trunc_q <= (33'(len_q) + 33'(bo_q)) > (33'(MAX_SEG) * 33'(bs_q));
			end
			F_DIV2_WAIT: begin
				if (div_done) begin
					quo_q <= div_quotient;
					drv_q <= div_remainder[DRV_W-1:0];
				end
			end
			F_MUL_LO: prod_q <= PROD_W'(quo_q[MUL_SPLIT-1:0]) * PROD_W'(bs_q);
			F_MUL_HI: begin
				acc_q  <= POS_W'(prod_q);
				prod_q <= PROD_W'(quo_q[POS_W-1:MUL_SPLIT]) * PROD_W'(bs_q);
			end
			F_ADD:    acc_q <= acc_q + {prod_q[POS_W-MUL_SPLIT-1:0], {MUL_SPLIT{1'b0}}};
			default: begin
			end
		endcase
	end

	always_comb begin
		push_data.cmd         = cmd_q;
		push_data.drv0        = drv_q;
		push_data.data_drives = dd_q;
		push_data.qbase       = acc_q;
		push_data.bo          = bo_q;
		push_data.bs          = bs_q;
		push_data.len         = len_q;
		push_data.trunc       = trunc_q;
		push_data.miss_en     = miss_en_q;
		push_data.miss_idx    = miss_idx_q;
		push_data.miss_par    = miss_par_q;
	end

`ifndef SYNTHESIS
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == F_DIV1_WAIT || state_q == F_DIV2_WAIT))
		else $error("divider finished outside a wait state");
`endif

endmodule

### rtl/rsu_queue.sv
// Descriptor queue between the front end and the segment emitter.
// Uses rsu_pkg for the descriptor type.
module rsu_queue
	import rsu_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  desc_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output desc_t pop_data
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	desc_t           entry_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push, pop;

	assign push_ready = count_q != CntW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("descriptor queue count beyond depth");
`endif

endmodule

### rtl/rsu_back.sv
// Segment emitter: walks a descriptor one stripe unit per cycle, unless the output stalls,
// into an output register. Uses rsu_pkg.
module rsu_back
	import rsu_pkg::*;
#(
	parameter int MAX_SEG = MAX_SEGMENTS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  desc_valid,
	output logic  desc_ready,
	input  desc_t desc,
	output logic  out_valid,
	input  logic  out_ready,
	output seg_t  out_seg
);

	localparam int SegW = $clog2(MAX_SEG + 1);

	logic             active_q;
	logic             out_valid_q;
	desc_t            desc_q;
	logic             first_q;
	logic [DRV_W-1:0] drv_q;
	logic [POS_W-1:0] qbase_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] boff_q;
	logic [SegW-1:0]  nseg_q;
	seg_t             seg_q;

	logic             load, emit;
	logic [BS_W-1:0]  seg_full, seg_len;
	logic             seg_last, miss_data;
	act_t             act;
	logic             drv_wrap;

	assign desc_ready = !active_q;
	assign load       = desc_valid && !active_q;
	assign emit       = active_q && (!out_valid_q || out_ready);

	always_comb begin
		seg_full  = first_q ? desc_q.bs - desc_q.bo : desc_q.bs;
		seg_len   = (rem_q < LEN_W'(seg_full)) ? rem_q[BS_W-1:0] : seg_full;
		seg_last  = (rem_q == LEN_W'(seg_len)) || (nseg_q == SegW'(MAX_SEG - 1));
		miss_data = desc_q.miss_en && ({1'b0, drv_q} == desc_q.miss_idx);
		drv_wrap  = (drv_q + 1'b1) == desc_q.data_drives;
		if (!desc_q.cmd)
			act = miss_data ? ACT_RECON_READ : ACT_READ;
		else if (miss_data)
			act = ACT_DEGRADED;
		else if (desc_q.miss_par)
			act = ACT_WRITE_NOPAR;
		else
			act = ACT_WRITE_RMW;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (emit)
				out_valid_q <= 1'b1;
			if (load)
				active_q <= 1'b1;
			else if (emit && seg_last)
				active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			desc_q  <= desc;
			first_q <= 1'b1;
			drv_q   <= desc.drv0;
			qbase_q <= desc.qbase;
			rem_q   <= desc.len;
			boff_q  <= '0;
			nseg_q  <= '0;
		end else if (emit) begin
			first_q <= 1'b0;
			rem_q   <= rem_q - LEN_W'(seg_len);
			boff_q  <= boff_q + LEN_W'(seg_len);
			nseg_q  <= nseg_q + 1'b1;
			if (drv_wrap) begin
				drv_q   <= '0;
				qbase_q <= qbase_q + POS_W'(desc_q.bs);
			end else begin
				drv_q <= drv_q + 1'b1;
			end
		end
		if (emit) begin
			seg_q.drive          <= drv_q;
			seg_q.drive_offset   <= first_q ? qbase_q + POS_W'(desc_q.bo) : qbase_q;
			seg_q.segment_length <= seg_len;
			seg_q.buffer_offset  <= boff_q;
			seg_q.action         <= act;
			seg_q.overflow       <= desc_q.trunc;
			seg_q.last           <= seg_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_seg   = seg_q;

`ifndef SYNTHESIS
	a_seg_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (nseg_q < SegW'(MAX_SEG)))
		else $error("segment count past limit");
	a_seg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (seg_len != '0 && rem_q != '0))
		else $error("empty segment emitted");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && seg_last) |=> out_valid_q && out_seg.last)
		else $error("final segment not flagged");
`endif

endmodule

### test/segment_checker.sv
`timescale 1ns / 100ps
// Segment checker for the RAID4 request segmenter: tracks register writes, predicts
// the drive segments of every accepted request and compares each delivered segment.
// Depends on rsu_pkg for widths, action codes, register indexes and the segment type.
module segment_checker
	import rsu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BS_W-1:0]      cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 command,
	input  logic [POS_W-1:0]     byte_offset,
	input  logic [LEN_W-1:0]     req_length,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [DRV_W-1:0]     drive,
	input  logic [POS_W-1:0]     drive_offset,
	input  logic [BS_W-1:0]      segment_length,
	input  logic [LEN_W-1:0]     buffer_offset,
	input  logic [ACT_W-1:0]     action,
	input  logic                 overflow,
	input  logic                 last,
	output int                   errors,
	output int                   pending,
	output int                   segments,
	output int                   truncated_segs
);

	localparam logic [BS_W-1:0] RST_UNIT_BYTES    = 17'd4096;
	localparam logic [DC_W-1:0] RST_DRIVE_COUNT   = 5'd4;
	localparam logic [DC_W-1:0] RST_MISSING_DRIVE = 5'd16;

	logic [BS_W-1:0] cfg_bs;
	logic [DC_W-1:0] cfg_dc;
	logic [DC_W-1:0] cfg_md;
	seg_t            expected_segs[$];
	seg_t            want;
	int              err_count;
	int              seg_count;
	int              trunc_count;

	task automatic report(input string msg);
		err_count++;
		$display("ERROR %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] exp_val);
		if (got !== exp_val)
			report($sformatf("segment %0d %s: got 0x%0h, expected 0x%0h",
				seg_count, name, got, exp_val));
	endtask

	function automatic void predict_segments(input logic is_write,
			input logic [POS_W-1:0] off, input logic [LEN_W-1:0] len);
		longint unsigned pos, rem, done, bse, dce, ndata, blk, bo, seg, drv;
		bit              miss_data, miss_par;
		seg_t            batch[$];
		seg_t            s;
		pos  = 64'(off);
		rem  = 64'(len);
		done = 0;
		bse  = 64'(cfg_bs);
		if (bse < 1) bse = 1;
		if (bse > BS_MAX) bse = BS_MAX;
		dce = 64'(cfg_dc);
		if (dce < DC_MIN) dce = DC_MIN;
		if (dce > MAX_DRIVES) dce = MAX_DRIVES;
		ndata = dce - 1;
		while (rem > 0 && batch.size() < MAX_SEGMENTS) begin
			blk = pos / bse;
			bo  = pos % bse;
			seg = bse - bo;
			if (seg > rem) seg = rem;
			drv       = blk % ndata;
			miss_data = (cfg_md < dce) && (drv == cfg_md);
			miss_par  = (cfg_md == ndata);
			s.drive          = DRV_W'(drv);
			s.drive_offset   = POS_W'((blk / ndata) * bse + bo);
			s.segment_length = BS_W'(seg);
			s.buffer_offset  = LEN_W'(done);
			if (!is_write)
				s.action = miss_data ? ACT_RECON_READ : ACT_READ;
			else if (miss_data)
				s.action = ACT_DEGRADED;
			else if (miss_par)
				s.action = ACT_WRITE_NOPAR;
			else
				s.action = ACT_WRITE_RMW;
			s.overflow = 1'b0;
			s.last     = 1'b0;
			batch.push_back(s);
			pos  += seg;
			rem  -= seg;
			done += seg;
		end
		foreach (batch[k]) begin
			batch[k].overflow = (rem > 0);
			batch[k].last     = (k == batch.size() - 1);
			expected_segs.push_back(batch[k]);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_bs = RST_UNIT_BYTES;
			cfg_dc = RST_DRIVE_COUNT;
			cfg_md = RST_MISSING_DRIVE;
			expected_segs.delete();
			err_count   = 0;
			seg_count   = 0;
			trunc_count = 0;
			errors         <= 0;
			pending        <= 0;
			segments       <= 0;
			truncated_segs <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_segs.size() == 0) begin
					report($sformatf("segment for drive %0d with no request outstanding", drive));
				end else begin
					want = expected_segs.pop_front();
					check_field("drive", 64'(drive), 64'(want.drive));
					check_field("drive_offset", 64'(drive_offset), 64'(want.drive_offset));
					check_field("segment_length", 64'(segment_length),
						64'(want.segment_length));
					check_field("buffer_offset", 64'(buffer_offset), 64'(want.buffer_offset));
					check_field("action", 64'(action), 64'(want.action));
					check_field("overflow", 64'(overflow), 64'(want.overflow));
					check_field("last", 64'(last), 64'(want.last));
				end
				seg_count++;
				if (overflow) trunc_count++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_UNIT_BYTES:    cfg_bs = cfg_data;
					REG_DRIVE_COUNT:   cfg_dc = cfg_data[DC_W-1:0];
					REG_MISSING_DRIVE: cfg_md = cfg_data[DC_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_segments(command, byte_offset, req_length);
			errors         <= err_count;
			pending        <= expected_segs.size();
			segments       <= seg_count;
			truncated_segs <= trunc_count;
		end
	end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Top of the RAID4 request segmenter testbench: clock, reset, request and register
// stimulus, output back-pressure and the final verdict. Needs rsu_pkg, the block and segment_checker.
module testbench;
	import rsu_pkg::*;

	localparam logic                 CMD_READ      = 1'b0;
	localparam logic                 CMD_WRITE     = 1'b1;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE     = 2'd3;
	localparam logic [POS_W-1:0]     POS_MAX       = 48'hFFFF_FFFF_FFFF;
	localparam logic [LEN_W-1:0]     LEN_MAX       = 32'hFFFF_FFFF;
	localparam logic [BS_W-1:0]      RST_BS        = 17'd4096;
	localparam int                   IDLE_PCT      = 10;
	localparam int                   DRAIN_CYCLES  = 120;
	localparam int                   HOLD_CYCLES   = 400;
	localparam int                   RAND_PHASES   = 8;
	localparam int                   PHASE_ITEMS   = 50;
	localparam longint               WATCHDOG_NS   = 64'd8_000_000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BS_W-1:0]      cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 command;
	logic [POS_W-1:0]     byte_offset;
	logic [LEN_W-1:0]     req_length;
	logic                 out_valid;
	logic                 out_ready;
	logic [DRV_W-1:0]     drive;
	logic [POS_W-1:0]     drive_offset;
	logic [BS_W-1:0]      segment_length;
	logic [LEN_W-1:0]     buffer_offset;
	logic [ACT_W-1:0]     action;
	logic                 overflow;
	logic                 last;

	int              errors;
	int              pending;
	int              segments;
	int              truncated_segs;
	int              in_idle_pct   = IDLE_PCT;
	int              out_stall_pct = IDLE_PCT;
	int              hold_left     = 0;
	int              items_sent    = 0;
	int              zero_items    = 0;
	int              settings      = 0;
	logic [BS_W-1:0] cur_bs;

	raid4_request_segmenter_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.byte_offset    (byte_offset),
		.req_length     (req_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drive          (drive),
		.drive_offset   (drive_offset),
		.segment_length (segment_length),
		.buffer_offset  (buffer_offset),
		.action         (action),
		.overflow       (overflow),
		.last           (last)
	);

	segment_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.byte_offset    (byte_offset),
		.req_length     (req_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drive          (drive),
		.drive_offset   (drive_offset),
		.segment_length (segment_length),
		.buffer_offset  (buffer_offset),
		.action         (action),
		.overflow       (overflow),
		.last           (last),
		.errors         (errors),
		.pending        (pending),
		.segments       (segments),
		.truncated_segs (truncated_segs)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(WATCHDOG_NS);
		$display("Timeout with %0d segments still expected", pending);
		$display("Verification failed");
		$finish;
	end

	// hold off the output for a counted stretch when asked, else stall at random
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (out_stall_pct == 0) || ($urandom_range(99) >= out_stall_pct);
			end
		end
	end

	task automatic send_req(input logic cmd, input logic [POS_W-1:0] off,
			input logic [LEN_W-1:0] len);
		if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		byte_offset <= off;
		req_length  <= len;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		if (len == 0) zero_items++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BS_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// drop the request valid and let every expected segment drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [BS_W-1:0] bs, input logic [DC_W-1:0] dc,
			input logic [DC_W-1:0] md);
		wait_idle();
		write_reg(REG_UNIT_BYTES, bs);
		write_reg(REG_DRIVE_COUNT, BS_W'(dc));
		write_reg(REG_MISSING_DRIVE, BS_W'(md));
		cfg_valid <= 1'b0;
		cur_bs = bs;
		settings++;
	endtask

	task automatic random_setting();
		logic [BS_W-1:0] bs;
		logic [DC_W-1:0] dc;
		logic [DC_W-1:0] md;
		int              dce;
		int              r;
		r = $urandom_range(99);
		if (r < 30) bs = BS_W'($urandom_range(1, 16));
		else if (r < 60) bs = BS_W'($urandom_range(17, 4096));
		else if (r < 80) bs = BS_W'($urandom_range(4097, 131071));
		else if (r < 90) bs = BS_W'($urandom_range(1));
		else bs = BS_W'(BS_MAX);
		dc  = ($urandom_range(99) < 80) ? DC_W'($urandom_range(DC_MIN, MAX_DRIVES))
			: DC_W'($urandom_range(31));
		dce = (dc < DC_MIN) ? DC_MIN : (dc > MAX_DRIVES) ? MAX_DRIVES : int'(dc);
		r   = $urandom_range(99);
		if (r < 30) md = DC_W'(MAX_DRIVES);
		else if (r < 40) md = DC_W'($urandom_range(dce, 31));
		else if (r < 70) md = DC_W'($urandom_range(0, dce - 2));
		else md = DC_W'(dce - 1);
		configure(bs, dc, md);
	endtask

	task automatic run_random(input int n);
		int unsigned      bse;
		logic [LEN_W-1:0] len;
		logic [POS_W-1:0] off;
		int               r;
		bse = (cur_bs == 0) ? 1 : (cur_bs > BS_MAX) ? BS_MAX : cur_bs;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 4) len = 0;
			else if (r < 66) len = $urandom_range(1, 4 * bse);
			else if (r < 78) len = bse * $urandom_range(1, 8);
			else if (r < 90) len = bse * $urandom_range(60, 68) + $urandom_range(2);
			else len = $urandom;
			r = $urandom_range(99);
			if (r < 45) off = {16'($urandom), 32'($urandom)};
			else if (r < 70) off = POS_W'($urandom_range(0, 8 * bse));
			else if (r < 88) off = POS_W'(bse) * $urandom_range(0, 4000);
			else off = POS_MAX - $urandom_range(0, 4 * bse);
			send_req(1'($urandom_range(1)), off, len);
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		command     <= CMD_READ;
		byte_offset <= '0;
		req_length  <= '0;
		cur_bs = RST_BS;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: single byte, exact block, crossing, zero, top of space, segment limit
		send_req(CMD_READ, 0, 1);
		send_req(CMD_WRITE, 0, 4096);
		send_req(CMD_READ, 4095, 2);
		send_req(CMD_WRITE, 100, 3 * 4096);
		send_req(CMD_READ, 12345, 0);
		send_req(CMD_WRITE, POS_MAX, LEN_MAX);
		send_req(CMD_READ, 0, 64 * 4096);
		send_req(CMD_READ, 0, 64 * 4096 + 1);
		send_req(CMD_WRITE, 1, 64 * 4096);

		// missing data drive, plus a write to the unused register index
		wait_idle();
		write_reg(REG_MISSING_DRIVE, 17'd1);
		write_reg(IDX_SPARE, 17'h1FFFF);
		cfg_valid <= 1'b0;
		settings++;
		send_req(CMD_READ, 0, 3 * 4096);
		send_req(CMD_WRITE, 0, 3 * 4096);

		configure(RST_BS, 5'd4, 5'd3);
		send_req(CMD_READ, 2048, 4 * 4096);
		send_req(CMD_WRITE, 2048, 4 * 4096);

		configure(17'd0, 5'd0, 5'd31);
		send_req(CMD_READ, 5, 10);
		send_req(CMD_WRITE, POS_MAX - 3, 7);

		configure(17'h1FFFF, 5'd31, 5'd15);
		send_req(CMD_WRITE, 65535, 65538);
		send_req(CMD_READ, 0, 1);

		configure(BS_W'(BS_MAX), 5'd16, 5'd0);
		send_req(CMD_READ, 0, LEN_MAX);
		send_req(CMD_WRITE, {16'($urandom), 32'($urandom)}, 200000);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			random_setting();
			if (ph == 4) begin
				in_idle_pct   = 0;
				out_stall_pct = 0;
			end else begin
				in_idle_pct   = IDLE_PCT;
				out_stall_pct = IDLE_PCT;
			end
			if (ph == 2) hold_left = HOLD_CYCLES;
			run_random(PHASE_ITEMS);
		end

		wait_idle();
		$display("Covered %0d requests (%0d of zero length) across %0d register settings",
			items_sent, zero_items, settings);
		$display("Checked %0d segments, %0d of them from truncated requests",
			segments, truncated_segs);
		if (errors == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### raid4_request_segmenter_unit.f
rtl/rsu_pkg.sv
rtl/rsu_divider.sv
rtl/rsu_front.sv
rtl/rsu_queue.sv
rtl/rsu_back.sv
rtl/raid4_request_segmenter_unit.sv
test/segment_checker.sv
test/testbench.sv
